@@ sv/asa_pkg.sv @@
// Shared types, codes and constants of the atlas slot allocator.
package asa_pkg;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_TOUCH   = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_FIND    = 3'd4;

    localparam logic [3:0] ST_PLACED    = 4'd0;
    localparam logic [3:0] ST_REUSED    = 4'd1;
    localparam logic [3:0] ST_REJECTED  = 4'd2;
    localparam logic [3:0] ST_NO_SPACE  = 4'd3;
    localparam logic [3:0] ST_TOUCHED   = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_RELEASED  = 4'd6;
    localparam logic [3:0] ST_RESET     = 4'd7;
    localparam logic [3:0] ST_FOUND     = 4'd8;

    localparam int unsigned CLASS_PX [4] = '{72, 96, 128, 160};
    localparam int unsigned MAX_SIDE = 160;

    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_FREE,
        SCAN_LRU
    } t_scan;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_HIT,
        RES_PLACE
    } t_res_sel;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] asset_id;
        logic [15:0] bucket_id;
        logic [11:0] req_width;
        logic [11:0] req_height;
        logic [63:0] frame;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  page_index;
        logic [31:0] page_generation;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [9:0]  alloc_width;
        logic [9:0]  alloc_height;
        logic        evicted_valid;
        logic [31:0] evicted_id;
    } t_res;

    typedef struct packed {
        logic       ld_req;
        logic       clr_start;
        logic       pages_reset;
        logic       scan_start;
        t_scan      scan_mode;
        logic       wr_owner;
        logic       owner_set;
        logic       wr_frame;
        logic       wr_dims;
        logic       new_page;
        logic       res_ld;
        t_res_sel   res_sel;
        logic [3:0] res_status;
        logic       res_evict;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       scan_done;
        logic       scan_found;
        logic       req_ok;
        logic       id_zero;
        logic       reuse_ok;
        logic       pages_full;
        logic [2:0] cmd;
    } t_dp_sts;

endpackage

@@ sv/asa_item_if.sv @@
// Valid/ready channel carrying one item of type T.
interface asa_item_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/atlas_slot_allocator_lru.sv @@
// Top level of the atlas slot allocator with size classes and LRU eviction.
//
//   channel  | dir | type  | content
//   i_req    | in  | t_req | cmd, asset_id, bucket_id, req_width, req_height, frame
//   o_res    | out | t_res | status, page, generation, position, size, eviction
//
// One item at a time: an item is taken only in the idle state. A slot scan walks the
// slots of the pages it visits; free-slot and LRU scans skip pages of another bucket
// or size class. An allocate runs up to three scans (owner, free slot, LRU).
// After reset and on a reset-all item the owner memory is cleared one entry a
// cycle while no item is taken.
// A finished result waits in the output register; the next item is accepted meanwhile.
module atlas_slot_allocator_lru #(
    parameter int unsigned PAGE_SIZE      = 1024,
    parameter int unsigned GUTTER         = 2,
    parameter int unsigned MAX_PAGES      = 8,
    parameter int unsigned SLOTS_PER_PAGE = 169
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asa_item_if.sink    i_req,
    asa_item_if.source  o_res
);
    import asa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_res    w_res;

    asa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    asa_datapath #(
        .PAGE_SIZE      (PAGE_SIZE),
        .GUTTER         (GUTTER),
        .MAX_PAGES      (MAX_PAGES),
        .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    assign o_res.data = w_res;
endmodule

@@ sv/asa_datapath.sv @@
// Allocator datapath: slot memories, page tables, slot scanner and result register.
module asa_datapath #(
    parameter int unsigned PAGE_SIZE      = 1024,
    parameter int unsigned GUTTER         = 2,
    parameter int unsigned MAX_PAGES      = 8,
    parameter int unsigned SLOTS_PER_PAGE = 169
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  asa_pkg::t_req   i_req,
    input  asa_pkg::t_dp_cmd i_cmd,
    output asa_pkg::t_dp_sts o_sts,
    output asa_pkg::t_res   o_res
);
    import asa_pkg::*;

    localparam int unsigned TOTAL = MAX_PAGES * SLOTS_PER_PAGE;
    localparam int unsigned KW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned KCW   = $clog2(TOTAL + 1);
    localparam int unsigned PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned PCW   = $clog2(MAX_PAGES + 1);
    localparam int unsigned SW    = $clog2(SLOTS_PER_PAGE + 1);
    localparam int unsigned XW    = $clog2(PAGE_SIZE + 1);
    localparam int unsigned LIMIT = PAGE_SIZE - 2 * GUTTER;

    localparam int unsigned CELL0 = CLASS_PX[0] + 2 * GUTTER;
    localparam int unsigned CELL1 = CLASS_PX[1] + 2 * GUTTER;
    localparam int unsigned CELL2 = CLASS_PX[2] + 2 * GUTTER;
    localparam int unsigned CELL3 = CLASS_PX[3] + 2 * GUTTER;
    localparam int unsigned PR0   = PAGE_SIZE / CELL0;
    localparam int unsigned PR1   = PAGE_SIZE / CELL1;
    localparam int unsigned PR2   = PAGE_SIZE / CELL2;
    localparam int unsigned PR3   = PAGE_SIZE / CELL3;
    localparam int unsigned N0    = (PR0 * PR0 > SLOTS_PER_PAGE) ? SLOTS_PER_PAGE : PR0 * PR0;
    localparam int unsigned N1    = (PR1 * PR1 > SLOTS_PER_PAGE) ? SLOTS_PER_PAGE : PR1 * PR1;
    localparam int unsigned N2    = (PR2 * PR2 > SLOTS_PER_PAGE) ? SLOTS_PER_PAGE : PR2 * PR2;
    localparam int unsigned N3    = (PR3 * PR3 > SLOTS_PER_PAGE) ? SLOTS_PER_PAGE : PR3 * PR3;

    localparam int unsigned CELL    [4] = '{CELL0, CELL1, CELL2, CELL3};
    localparam int unsigned PER_ROW [4] = '{PR0, PR1, PR2, PR3};
    localparam int unsigned NSLOT   [4] = '{N0, N1, N2, N3};

    logic [31:0] r_owner_mem [TOTAL];
    logic [63:0] r_frame_mem [TOTAL];
    logic [19:0] r_dims_mem  [TOTAL];

    logic [15:0] r_pg_bucket [MAX_PAGES];
    logic [1:0]  r_pg_cls    [MAX_PAGES];
    logic [31:0] r_pg_gen    [MAX_PAGES];

    t_req        r_req;
    logic [PCW-1:0] r_pages;
    logic [31:0] r_next_gen;

    logic        r_clr_busy;
    logic [KW-1:0] r_clr_k;

    logic        r_run;
    t_scan       r_mode;
    logic [PIW-1:0] r_p;
    logic [SW-1:0] r_s;
    logic [XW-1:0] r_col;
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_y;
    logic [KW-1:0] r_k;
    logic [KCW-1:0] r_base;

    logic        r_d_valid;
    logic        r_d_end;
    logic [PIW-1:0] r_d_p;
    logic [XW-1:0] r_d_x;
    logic [XW-1:0] r_d_y;
    logic [KW-1:0] r_d_k;
    logic [31:0] r_d_gen;
    logic        r_d_bmatch;

    logic [31:0] r_rd_owner;
    logic [63:0] r_rd_frame;
    logic [19:0] r_rd_dims;

    logic        r_done;
    logic        r_found;
    logic        r_got;
    logic [63:0] r_best;

    logic [PIW-1:0] r_hit_p;
    logic [KW-1:0] r_hit_k;
    logic [XW-1:0] r_hit_x;
    logic [XW-1:0] r_hit_y;
    logic [31:0] r_hit_gen;
    logic [19:0] r_hit_dims;
    logic [31:0] r_hit_owner;
    logic        r_hit_bmatch;

    t_res        r_res;
    t_res        n_res;

    logic [11:0] w_max;
    logic [1:0]  w_cls;
    logic        w_req_ok;
    logic [1:0]  w_pc;
    logic        w_ok;
    logic        w_last_slot;
    logic        w_last_page;
    logic        w_elem_end;
    logic [KCW-1:0] w_next_base;
    logic        w_match;
    logic [PIW-1:0] w_new_p;

    always_comb begin
        w_max = (r_req.req_width > r_req.req_height) ? r_req.req_width : r_req.req_height;
        if (w_max <= 12'(CLASS_PX[0])) begin
            w_cls = 2'd0;
        end else if (w_max <= 12'(CLASS_PX[1])) begin
            w_cls = 2'd1;
        end else if (w_max <= 12'(CLASS_PX[2])) begin
            w_cls = 2'd2;
        end else begin
            w_cls = 2'd3;
        end
        w_req_ok = (r_req.asset_id != 32'd0) && (r_req.bucket_id != 16'd0)
            && (r_req.req_width != 12'd0) && (r_req.req_height != 12'd0)
            && ({20'd0, r_req.req_width} <= 32'(LIMIT))
            && ({20'd0, r_req.req_height} <= 32'(LIMIT))
            && (w_max <= 12'(MAX_SIDE));

        w_pc        = r_pg_cls[r_p];
        w_ok        = (r_mode == SCAN_FIND)
            || ((r_pg_bucket[r_p] == r_req.bucket_id) && (w_pc == w_cls));
        w_last_slot = (r_s == SW'(NSLOT[w_pc] - 1));
        w_last_page = ((PCW'(r_p) + PCW'(1)) == r_pages);
        w_elem_end  = !w_ok || w_last_slot;
        w_next_base = r_base + KCW'(SLOTS_PER_PAGE);
        w_new_p     = r_pages[PIW-1:0];

        case (r_mode)
            SCAN_FIND: w_match = r_d_valid && (r_rd_owner == r_req.asset_id);
            SCAN_FREE: w_match = r_d_valid && (r_rd_owner == 32'd0);
            SCAN_LRU:  w_match = r_d_valid && (r_rd_owner != 32'd0)
                && (r_rd_frame < r_req.frame) && (r_rd_frame < r_best);
            default:   w_match = 1'b0;
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_owner_mem[r_clr_k] <= 32'd0;
        end else if (i_cmd.wr_owner) begin
            r_owner_mem[r_hit_k] <= i_cmd.owner_set ? r_req.asset_id : 32'd0;
        end
        if (i_cmd.wr_frame) begin
            r_frame_mem[r_hit_k] <= r_req.frame;
        end
        if (i_cmd.wr_dims) begin
            r_dims_mem[r_hit_k] <= {r_req.req_height[9:0], r_req.req_width[9:0]};
        end
        r_rd_owner <= r_owner_mem[r_k];
        r_rd_frame <= r_frame_mem[r_k];
        r_rd_dims  <= r_dims_mem[r_k];
    end

    // page tables and request
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_req <= i_req;
        end
        if (i_cmd.new_page) begin
            r_pg_bucket[w_new_p] <= r_req.bucket_id;
            r_pg_cls[w_new_p]    <= w_cls;
            r_pg_gen[w_new_p]    <= r_next_gen;
        end
    end

    // scanner, clear sweep, page counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages    <= '0;
            r_next_gen <= '0;
            r_clr_busy <= 1'b0;
            r_clr_k    <= '0;
            r_run      <= 1'b0;
            r_mode     <= SCAN_FIND;
            r_d_valid  <= 1'b0;
            r_d_end    <= 1'b0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_got      <= 1'b0;
        end else begin
            r_done <= 1'b0;

            if (i_cmd.clr_start) begin
                r_clr_busy <= 1'b1;
                r_clr_k    <= '0;
            end else if (r_clr_busy) begin
                if (r_clr_k == KW'(TOTAL - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_k <= r_clr_k + KW'(1);
                end
            end

            if (i_cmd.pages_reset) begin
                r_pages <= '0;
            end

            if (i_cmd.new_page) begin
                r_pages      <= r_pages + PCW'(1);
                r_next_gen   <= r_next_gen + 32'd1;
                r_hit_p      <= w_new_p;
                r_hit_k      <= KW'(w_new_p * SLOTS_PER_PAGE);
                r_hit_x      <= XW'(GUTTER);
                r_hit_y      <= XW'(GUTTER);
                r_hit_gen    <= r_next_gen;
            end

            // issue
            if (r_run) begin
                r_d_valid  <= w_ok;
                r_d_end    <= w_elem_end && w_last_page;
                r_d_p      <= r_p;
                r_d_x      <= r_x;
                r_d_y      <= r_y;
                r_d_k      <= r_k;
                r_d_gen    <= r_pg_gen[r_p];
                r_d_bmatch <= (r_pg_bucket[r_p] == r_req.bucket_id);
                if (w_elem_end) begin
                    r_p    <= r_p + PIW'(1);
                    r_s    <= '0;
                    r_col  <= '0;
                    r_x    <= XW'(GUTTER);
                    r_y    <= XW'(GUTTER);
                    r_base <= w_next_base;
                    r_k    <= w_next_base[KW-1:0];
                    if (w_last_page) begin
                        r_run <= 1'b0;
                    end
                end else begin
                    r_s <= r_s + SW'(1);
                    r_k <= r_k + KW'(1);
                    if (r_col == XW'(PER_ROW[w_pc] - 1)) begin
                        r_col <= '0;
                        r_x   <= XW'(GUTTER);
                        r_y   <= r_y + XW'(CELL[w_pc]);
                    end else begin
                        r_col <= r_col + XW'(1);
                        r_x   <= r_x + XW'(CELL[w_pc]);
                    end
                end
            end else begin
                r_d_valid <= 1'b0;
                r_d_end   <= 1'b0;
            end

            // evaluate
            if (w_match) begin
                r_hit_p      <= r_d_p;
                r_hit_k      <= r_d_k;
                r_hit_x      <= r_d_x;
                r_hit_y      <= r_d_y;
                r_hit_gen    <= r_d_gen;
                r_hit_dims   <= r_rd_dims;
                r_hit_owner  <= r_rd_owner;
                r_hit_bmatch <= r_d_bmatch;
            end
            if (r_mode == SCAN_LRU) begin
                if (w_match) begin
                    r_best <= r_rd_frame;
                    r_got  <= 1'b1;
                end
                if (r_d_end) begin
                    r_done  <= 1'b1;
                    r_found <= r_got || w_match;
                end
            end else if (w_match) begin
                r_done    <= 1'b1;
                r_found   <= 1'b1;
                r_run     <= 1'b0;
                r_d_valid <= 1'b0;
                r_d_end   <= 1'b0;
            end else if (r_d_end) begin
                r_done  <= 1'b1;
                r_found <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_run     <= (r_pages != '0);
                r_mode    <= i_cmd.scan_mode;
                r_p       <= '0;
                r_s       <= '0;
                r_col     <= '0;
                r_x       <= XW'(GUTTER);
                r_y       <= XW'(GUTTER);
                r_k       <= '0;
                r_base    <= '0;
                r_got     <= 1'b0;
                r_best    <= '1;
                r_d_valid <= 1'b0;
                r_d_end   <= 1'b0;
                r_done    <= (r_pages == '0);
                r_found   <= 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        n_res        = '0;
        n_res.status = i_cmd.res_status;
        case (i_cmd.res_sel)
            RES_HIT, RES_PLACE: begin
                n_res.page_index      = 3'(r_hit_p);
                n_res.page_generation = r_hit_gen;
                n_res.pos_x           = 10'(r_hit_x);
                n_res.pos_y           = 10'(r_hit_y);
                if (i_cmd.res_sel == RES_HIT) begin
                    n_res.alloc_width  = r_hit_dims[9:0];
                    n_res.alloc_height = r_hit_dims[19:10];
                end else begin
                    n_res.alloc_width  = r_req.req_width[9:0];
                    n_res.alloc_height = r_req.req_height[9:0];
                end
                n_res.evicted_valid = i_cmd.res_evict;
                n_res.evicted_id    = i_cmd.res_evict ? r_hit_owner : 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        o_sts.clr_done   = !r_clr_busy;
        o_sts.scan_done  = r_done;
        o_sts.scan_found = r_found;
        o_sts.req_ok     = w_req_ok;
        o_sts.id_zero    = (r_req.asset_id == 32'd0);
        o_sts.reuse_ok   = r_hit_bmatch
            && ({2'b00, r_hit_dims[9:0]} == r_req.req_width)
            && ({2'b00, r_hit_dims[19:10]} == r_req.req_height);
        o_sts.pages_full = (r_pages == PCW'(MAX_PAGES));
        o_sts.cmd        = r_req.cmd;
        o_res            = r_res;
    end

    a_no_scan_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_clr_busy))
        else $error("scan running during clear sweep");
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= PCW'(MAX_PAGES))
        else $error("page count above limit");
    a_done_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_mode != SCAN_LRU)) |-> !r_d_valid)
        else $error("stage still valid after scan end");
endmodule

@@ sv/asa_ctrl.sv @@
// Allocator controller: sequences request decode, scans, writes and result hand-off.
module asa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  asa_pkg::t_dp_sts i_sts,
    output asa_pkg::t_dp_cmd o_cmd
);
    import asa_pkg::*;

    typedef enum logic [3:0] {
        S_CLR_GO,
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_FREE,
        S_LRU,
        S_PLACE,
        S_RESULT
    } t_state;

    t_state     r_state;
    logic [3:0] r_code;
    t_res_sel   r_sel;
    logic       r_evict;
    logic       r_reply;
    logic       r_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.scan_mode = SCAN_FIND;
        o_cmd.res_sel   = r_sel;
        o_cmd.res_status = r_code;
        o_cmd.res_evict  = r_evict;
        case (r_state)
            S_CLR_GO: o_cmd.clr_start = 1'b1;
            S_IDLE:   o_cmd.ld_req = i_in_valid;
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_ALLOC: o_cmd.scan_start = i_sts.req_ok;
                    CMD_TOUCH, CMD_RELEASE, CMD_FIND: o_cmd.scan_start = !i_sts.id_zero;
                    CMD_RESET: begin
                        o_cmd.clr_start   = 1'b1;
                        o_cmd.pages_reset = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FIND: begin
                if (i_sts.scan_done) begin
                    if (i_sts.scan_found) begin
                        case (i_sts.cmd)
                            CMD_ALLOC: begin
                                if (i_sts.reuse_ok) begin
                                    o_cmd.wr_frame = 1'b1;
                                end else begin
                                    o_cmd.wr_owner   = 1'b1;
                                    o_cmd.scan_start = 1'b1;
                                    o_cmd.scan_mode  = SCAN_FREE;
                                end
                            end
                            CMD_TOUCH:   o_cmd.wr_frame = 1'b1;
                            CMD_RELEASE: o_cmd.wr_owner = 1'b1;
                            default: begin
                            end
                        endcase
                    end else if (i_sts.cmd == CMD_ALLOC) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = SCAN_FREE;
                    end
                end
            end
            S_FREE: begin
                if (i_sts.scan_done && !i_sts.scan_found) begin
                    if (!i_sts.pages_full) begin
                        o_cmd.new_page = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = SCAN_LRU;
                    end
                end
            end
            S_PLACE: begin
                o_cmd.wr_owner  = 1'b1;
                o_cmd.owner_set = 1'b1;
                o_cmd.wr_frame  = 1'b1;
                o_cmd.wr_dims   = 1'b1;
            end
            S_RESULT: o_cmd.res_ld = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_GO;
            r_code      <= ST_RESET;
            r_sel       <= RES_PLAIN;
            r_evict     <= 1'b0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR_GO: r_state <= S_CLR;
                S_CLR: begin
                    if (i_sts.clr_done) begin
                        r_state <= r_reply ? S_RESULT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_sel   <= RES_PLAIN;
                    r_evict <= 1'b0;
                    r_reply <= 1'b0;
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (i_sts.cmd)
                        CMD_ALLOC: begin
                            if (i_sts.req_ok) begin
                                r_state <= S_FIND;
                            end else begin
                                r_code  <= ST_REJECTED;
                                r_state <= S_RESULT;
                            end
                        end
                        CMD_TOUCH, CMD_RELEASE, CMD_FIND: begin
                            if (i_sts.id_zero) begin
                                r_code  <= ST_NOT_FOUND;
                                r_state <= S_RESULT;
                            end else begin
                                r_state <= S_FIND;
                            end
                        end
                        CMD_RESET: begin
                            r_code  <= ST_RESET;
                            r_reply <= 1'b1;
                            r_state <= S_CLR;
                        end
                        default: begin
                            r_code  <= ST_REJECTED;
                            r_state <= S_RESULT;
                        end
                    endcase
                end
                S_FIND: begin
                    if (i_sts.scan_done) begin
                        if (i_sts.scan_found) begin
                            case (i_sts.cmd)
                                CMD_ALLOC: begin
                                    if (i_sts.reuse_ok) begin
                                        r_code  <= ST_REUSED;
                                        r_sel   <= RES_HIT;
                                        r_state <= S_RESULT;
                                    end else begin
                                        r_state <= S_FREE;
                                    end
                                end
                                CMD_TOUCH: begin
                                    r_code  <= ST_TOUCHED;
                                    r_state <= S_RESULT;
                                end
                                CMD_RELEASE: begin
                                    r_code  <= ST_RELEASED;
                                    r_state <= S_RESULT;
                                end
                                default: begin
                                    r_code  <= ST_FOUND;
                                    r_sel   <= RES_HIT;
                                    r_state <= S_RESULT;
                                end
                            endcase
                        end else if (i_sts.cmd == CMD_ALLOC) begin
                            r_state <= S_FREE;
                        end else begin
                            r_code  <= ST_NOT_FOUND;
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_FREE: begin
                    if (i_sts.scan_done) begin
                        if (i_sts.scan_found || !i_sts.pages_full) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_state <= S_LRU;
                        end
                    end
                end
                S_LRU: begin
                    if (i_sts.scan_done) begin
                        if (i_sts.scan_found) begin
                            r_evict <= 1'b1;
                            r_state <= S_PLACE;
                        end else begin
                            r_code  <= ST_NO_SPACE;
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_PLACE: begin
                    r_code  <= ST_PLACED;
                    r_sel   <= RES_PLACE;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the atlas slot allocator: directed table, then random items.
`timescale 1ns / 100ps
module tb;
    import asa_pkg::*;

    localparam int unsigned PAGE_PX  = 1024;
    localparam int unsigned GUT      = 2;
    localparam int unsigned NPAGES   = 8;
    localparam int unsigned SPP      = 169;
    localparam int unsigned NSLOTS   = NPAGES * SPP;
    localparam int unsigned N_RANDOM = 270;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    asa_item_if #(.T(t_req)) req_if ();
    asa_item_if #(.T(t_res)) res_if ();

    atlas_slot_allocator_lru uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    logic [15:0] pg_bucket [NPAGES];
    logic [1:0]  pg_cls [NPAGES];
    logic [31:0] pg_gen [NPAGES];
    logic [31:0] owner [NSLOTS];
    logic [63:0] last_frame [NSLOTS];
    logic [19:0] dims [NSLOTS];
    int unsigned pages_used;
    logic [31:0] gen_next;

    t_res        pending_res [$];
    int          errors;
    bit          stim_done;
    int unsigned res_count;
    logic [63:0] frame_now;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned cell_px(logic [1:0] c);
        return CLASS_PX[c] + 2 * GUT;
    endfunction

    function automatic int unsigned slots_of(logic [1:0] c);
        int unsigned r;
        int unsigned n;
        r = PAGE_PX / cell_px(c);
        n = r * r;
        return n > SPP ? SPP : n;
    endfunction

    function automatic int unsigned live_pages();
        return pages_used > NPAGES ? NPAGES : pages_used;
    endfunction

    function automatic bit lookup_owner(logic [31:0] id, output int unsigned pg,
                                        output int unsigned sl);
        pg = 0;
        sl = 0;
        if (id == 0) return 1'b0;
        for (int unsigned p = 0; p < live_pages(); p++)
            for (int unsigned s = 0; s < slots_of(pg_cls[p]); s++)
                if (owner[p * SPP + s] == id) begin
                    pg = p;
                    sl = s;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic t_res plain_res(logic [3:0] st);
        t_res r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic t_res slot_res(logic [3:0] st, int unsigned p, int unsigned s,
                                      bit ev, logic [31:0] ev_id);
        t_res r;
        int unsigned cols;
        int unsigned k;
        r = plain_res(st);
        cols = PAGE_PX / cell_px(pg_cls[p]);
        k = p * SPP + s;
        r.page_index = p[2:0];
        r.page_generation = pg_gen[p];
        r.pos_x = 10'((s % cols) * cell_px(pg_cls[p]) + GUT);
        r.pos_y = 10'((s / cols) * cell_px(pg_cls[p]) + GUT);
        r.alloc_width = dims[k][9:0];
        r.alloc_height = dims[k][19:10];
        r.evicted_valid = ev;
        r.evicted_id = ev ? ev_id : '0;
        return r;
    endfunction

    function automatic void fill_slot(int unsigned k, t_req q);
        owner[k] = q.asset_id;
        last_frame[k] = q.frame;
        dims[k] = {q.req_height[9:0], q.req_width[9:0]};
    endfunction

    function automatic t_res alloc_outcome(t_req q);
        int unsigned m;
        int unsigned p;
        int unsigned s;
        int unsigned k;
        int unsigned ep;
        int unsigned es;
        logic [1:0]  c;
        logic [63:0] best;
        logic [31:0] victim;
        bit          got;
        m = q.req_width > q.req_height ? q.req_width : q.req_height;
        ep = 0;
        es = 0;
        got = 1'b0;
        best = '1;
        if (q.asset_id == 0 || q.bucket_id == 0 || q.req_width == 0 || q.req_height == 0 ||
            q.req_width > PAGE_PX - 2 * GUT || q.req_height > PAGE_PX - 2 * GUT ||
            m > MAX_SIDE)
            return plain_res(ST_REJECTED);
        c = m <= CLASS_PX[0] ? 2'd0 : m <= CLASS_PX[1] ? 2'd1 : m <= CLASS_PX[2] ? 2'd2 : 2'd3;
        if (lookup_owner(q.asset_id, p, s)) begin
            k = p * SPP + s;
            if (dims[k][9:0] == q.req_width && dims[k][19:10] == q.req_height &&
                pg_bucket[p] == q.bucket_id) begin
                last_frame[k] = q.frame;
                return slot_res(ST_REUSED, p, s, 1'b0, '0);
            end
            owner[k] = '0;
        end
        for (p = 0; p < live_pages() && !got; p++) begin
            if (pg_bucket[p] != q.bucket_id || pg_cls[p] != c) continue;
            for (s = 0; s < slots_of(c); s++)
                if (owner[p * SPP + s] == 0) begin
                    ep = p;
                    es = s;
                    got = 1'b1;
                    break;
                end
        end
        if (got) begin
            fill_slot(ep * SPP + es, q);
            return slot_res(ST_PLACED, ep, es, 1'b0, '0);
        end
        if (pages_used < NPAGES) begin
            p = pages_used;
            pg_bucket[p] = q.bucket_id;
            pg_cls[p] = c;
            pg_gen[p] = gen_next;
            gen_next++;
            pages_used++;
            fill_slot(p * SPP, q);
            return slot_res(ST_PLACED, p, 0, 1'b0, '0);
        end
        for (p = 0; p < live_pages(); p++) begin
            if (pg_bucket[p] != q.bucket_id || pg_cls[p] != c) continue;
            for (s = 0; s < slots_of(c); s++) begin
                k = p * SPP + s;
                if (owner[k] == 0 || last_frame[k] >= q.frame) continue;
                if (last_frame[k] < best) begin
                    best = last_frame[k];
                    ep = p;
                    es = s;
                    got = 1'b1;
                end
            end
        end
        if (!got) return plain_res(ST_NO_SPACE);
        k = ep * SPP + es;
        victim = owner[k];
        fill_slot(k, q);
        return slot_res(ST_PLACED, ep, es, 1'b1, victim);
    endfunction

    function automatic t_res slot_outcome(t_req q);
        int unsigned p;
        int unsigned s;
        case (q.cmd)
            CMD_ALLOC: return alloc_outcome(q);
            CMD_TOUCH: begin
                if (!lookup_owner(q.asset_id, p, s)) return plain_res(ST_NOT_FOUND);
                last_frame[p * SPP + s] = q.frame;
                return plain_res(ST_TOUCHED);
            end
            CMD_RELEASE: begin
                if (!lookup_owner(q.asset_id, p, s)) return plain_res(ST_NOT_FOUND);
                owner[p * SPP + s] = '0;
                return plain_res(ST_RELEASED);
            end
            CMD_RESET: begin
                pages_used = 0;
                foreach (owner[i]) owner[i] = '0;
                return plain_res(ST_RESET);
            end
            CMD_FIND: begin
                if (!lookup_owner(q.asset_id, p, s)) return plain_res(ST_NOT_FOUND);
                return slot_res(ST_FOUND, p, s, 1'b0, '0);
            end
            default: return plain_res(ST_REJECTED);
        endcase
    endfunction

    function automatic t_req mk_req(logic [2:0] c, logic [31:0] id, logic [15:0] b,
                                    logic [11:0] w, logic [11:0] h, logic [63:0] f);
        t_req q;
        q.cmd = c;
        q.asset_id = id;
        q.bucket_id = b;
        q.req_width = w;
        q.req_height = h;
        q.frame = f;
        return q;
    endfunction

    function automatic t_row mk_row(t_req q, bit typed, t_res r);
        t_row row;
        row.req = q;
        row.typed = typed;
        row.res = r;
        return row;
    endfunction

    function automatic t_res typed_slot(logic [3:0] st, logic [2:0] pg, logic [31:0] gen,
                                        logic [9:0] w, logic [9:0] h);
        t_res r;
        r = plain_res(st);
        r.page_index = pg;
        r.page_generation = gen;
        r.pos_x = 10'(GUT);
        r.pos_y = 10'(GUT);
        r.alloc_width = w;
        r.alloc_height = h;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req q;
        int unsigned sel;
        int unsigned c;
        sel = $urandom_range(0, 99);
        frame_now += 64'($urandom_range(0, 2));
        if (sel < 10) begin
            q = mk_req(3'($urandom), $urandom, 16'($urandom), 12'($urandom), 12'($urandom),
                       {$urandom, $urandom});
            return q;
        end
        c = $urandom_range(0, 3);
        q = mk_req(CMD_ALLOC, 32'($urandom_range(1, 70)), 16'($urandom_range(1, 3)),
                   12'($urandom_range(1, CLASS_PX[c])), 12'($urandom_range(1, CLASS_PX[c])),
                   frame_now);
        if (c > 0 && $urandom_range(0, 1)) q.req_width = 12'(CLASS_PX[c]);
        if (sel < 13) q.bucket_id = 16'($urandom);
        else if (sel < 15) q.asset_id = $urandom;
        if (sel >= 70 && sel < 78) q.cmd = CMD_TOUCH;
        else if (sel >= 78 && sel < 86) q.cmd = CMD_RELEASE;
        else if (sel >= 86 && sel < 98) q.cmd = CMD_FIND;
        else if (sel >= 98) q.cmd = CMD_RESET;
        return q;
    endfunction

    task automatic send_item(t_row row);
        int unsigned gap;
        t_res want;
        req_if.valid <= 1'b1;
        req_if.data <= row.req;
        do @(posedge i_clk); while (!req_if.ready);
        want = slot_outcome(row.req);
        if (row.typed) want = row.res;
        pending_res = {pending_res, want};
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_res(t_res got);
        t_res want;
        if (pending_res.size() == 0) begin
            $error("result with no item pending: status %0d", got.status);
            errors++;
            return;
        end
        want = pending_res.pop_front();
        if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.page_index != want.page_index) begin
            $error("page_index: expected %0d, actual %0d", want.page_index, got.page_index);
            errors++;
        end
        if (got.page_generation != want.page_generation) begin
            $error("page_generation: expected %0d, actual %0d", want.page_generation,
                   got.page_generation);
            errors++;
        end
        if (got.pos_x != want.pos_x) begin
            $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
            errors++;
        end
        if (got.pos_y != want.pos_y) begin
            $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
            errors++;
        end
        if (got.alloc_width != want.alloc_width) begin
            $error("alloc_width: expected %0d, actual %0d", want.alloc_width, got.alloc_width);
            errors++;
        end
        if (got.alloc_height != want.alloc_height) begin
            $error("alloc_height: expected %0d, actual %0d", want.alloc_height,
                   got.alloc_height);
            errors++;
        end
        if (got.evicted_valid != want.evicted_valid) begin
            $error("evicted_valid: expected %0d, actual %0d", want.evicted_valid,
                   got.evicted_valid);
            errors++;
        end
        if (got.evicted_id != want.evicted_id) begin
            $error("evicted_id: expected %0h, actual %0h", want.evicted_id, got.evicted_id);
            errors++;
        end
    endtask

    initial begin
        int unsigned hold;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            hold = (res_count == 40) ? 8000 : $urandom_range(0, 11);
            if (res_count > 120 && res_count < 160) hold = 0;
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            check_res(res_if.data);
            res_count++;
        end
    end

    initial begin
        t_row rows [$];
        t_res none;
        none = '0;
        errors = 0;
        stim_done = 1'b0;
        res_count = 0;
        frame_now = 64'd100;
        pages_used = 0;
        gen_next = '0;
        foreach (owner[i]) begin
            owner[i] = '0;
            last_frame[i] = '0;
            dims[i] = '0;
        end
        foreach (pg_gen[i]) begin
            pg_bucket[i] = '0;
            pg_cls[i] = '0;
            pg_gen[i] = '0;
        end
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = {rows, mk_row(mk_req(CMD_FIND, 32'd5, 16'd1, 12'd8, 12'd8, 64'd1), 1,
                             plain_res(ST_NOT_FOUND))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd0, 16'd1, 12'd8, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd2, 16'd0, 12'd8, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd2, 16'd1, 12'd0, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd2, 16'd1, 12'd8, 12'hFFF, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd2, 16'd1, 12'd161, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(3'd5, 32'd2, 16'd1, 12'd8, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(3'd7, 32'd2, 16'd1, 12'd8, 12'd8, 64'd1), 1,
                             plain_res(ST_REJECTED))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd1, 16'd1, 12'd72, 12'd1, 64'd10), 1,
                             typed_slot(ST_PLACED, 3'd0, 32'd0, 10'd72, 10'd1))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd1, 16'd1, 12'd72, 12'd1, 64'd11), 1,
                             typed_slot(ST_REUSED, 3'd0, 32'd0, 10'd72, 10'd1))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, '1, '1, 12'd160, 12'd160, '1), 1,
                             typed_slot(ST_PLACED, 3'd1, 32'd1, 10'd160, 10'd160))};
        rows = {rows, mk_row(mk_req(CMD_TOUCH, 32'd1, 16'd1, 12'd1, 12'd1, 64'd20), 1,
                             plain_res(ST_TOUCHED))};
        rows = {rows, mk_row(mk_req(CMD_FIND, 32'd1, 16'd1, 12'd1, 12'd1, 64'd20), 1,
                             typed_slot(ST_FOUND, 3'd0, 32'd0, 10'd72, 10'd1))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd3, 16'd1, 12'd96, 12'd73, 64'd21), 0,
                             none)};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd1, 16'd1, 12'd73, 12'd1, 64'd22), 0,
                             none)};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd4, 16'd2, 12'd128, 12'd128, 64'd23), 0,
                             none)};
        rows = {rows, mk_row(mk_req(CMD_RELEASE, 32'd0, 16'd1, 12'd1, 12'd1, 64'd24), 1,
                             plain_res(ST_NOT_FOUND))};
        rows = {rows, mk_row(mk_req(CMD_TOUCH, 32'd0, 16'd1, 12'd1, 12'd1, 64'd24), 1,
                             plain_res(ST_NOT_FOUND))};
        rows = {rows, mk_row(mk_req(CMD_FIND, 32'd0, 16'd1, 12'd1, 12'd1, 64'd24), 1,
                             plain_res(ST_NOT_FOUND))};
        rows = {rows, mk_row(mk_req(CMD_RELEASE, 32'd1, 16'd1, 12'd1, 12'd1, 64'd25), 0,
                             none)};
        rows = {rows, mk_row(mk_req(CMD_RESET, 32'd0, 16'd0, 12'd0, 12'd0, 64'd26), 1,
                             plain_res(ST_RESET))};
        rows = {rows, mk_row(mk_req(CMD_FIND, '1, 16'd1, 12'd1, 12'd1, 64'd27), 1,
                             plain_res(ST_NOT_FOUND))};
        rows = {rows, mk_row(mk_req(CMD_ALLOC, 32'd9, 16'd3, 12'd1, 12'd1, 64'd27), 0,
                             none)};
        foreach (rows[i]) send_item(rows[i]);

        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (n == 150) begin
                req_if.valid <= 1'b0;
                while (pending_res.size() > 0) @(posedge i_clk);
            end
            send_item(mk_row(random_req(), 0, none));
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/asa_pkg.sv
sv/asa_item_if.sv
sv/asa_datapath.sv
sv/asa_ctrl.sv
sv/atlas_slot_allocator_lru.sv
tb/tb.sv
